// ===== rtl/afrf_pkg.sv =====
package afrf_pkg;

    // Default sizes
    localparam int DEF_MAX_FRAME_BYTES = 240;
    localparam int DEF_SENDER_SLOTS    = 16;

    // Frame layout
    localparam int HDR_BYTES       = 19;
    localparam int TAG_BYTES       = 16;
    localparam int MIN_FRAME_BYTES = HDR_BYTES + TAG_BYTES;

    localparam logic [7:0] MAGIC_0  = 8'h48;
    localparam logic [7:0] MAGIC_1  = 8'h4C;
    localparam logic [7:0] VERSION  = 8'h01;
    localparam logic [7:0] IPAD     = 8'h36;
    localparam logic [7:0] OPAD     = 8'h5C;
    localparam logic [7:0] PAD_MARK = 8'h80;

    // Result status codes
    localparam logic [2:0] ST_FORWARD  = 3'd0;
    localparam logic [2:0] ST_BAD_LEN  = 3'd1;
    localparam logic [2:0] ST_BAD_HDR  = 3'd2;
    localparam logic [2:0] ST_BAD_NET  = 3'd3;
    localparam logic [2:0] ST_LEN_MISM = 3'd4;
    localparam logic [2:0] ST_BAD_TAG  = 3'd5;
    localparam logic [2:0] ST_REPLAY   = 3'd6;
    localparam logic [2:0] ST_TTL_ZERO = 3'd7;

    // Register indexes
    localparam logic [2:0] REG_NETWORK = 3'd0;
    localparam logic [2:0] REG_KEY0    = 3'd1;
    localparam logic [2:0] REG_KEY1    = 3'd2;
    localparam logic [2:0] REG_KEY2    = 3'd3;
    localparam logic [2:0] REG_KEY3    = 3'd4;

    typedef enum logic [2:0] {
        S_COLLECT,
        S_CHECK,
        S_FILL,
        S_START,
        S_HASH,
        S_LOOKUP,
        S_RESULT
    } afrf_state_t;

    // Sender table requests and answer
    typedef struct packed {
        logic scan;
        logic upd;
    } tbl_req_t;

    typedef struct packed {
        logic        done;
        logic        hit;
        logic [63:0] prev;
    } tbl_rsp_t;

endpackage

// ===== rtl/afrf_sha_core.sv =====
module afrf_sha_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         init,
    input  logic [511:0] block,
    output logic         busy,
    output logic         done,
    output logic [255:0] digest
);

    localparam logic [31:0] K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8];
    logic [5:0]  rnd_reg;
    logic        run_reg;
    logic        fin_reg;
    logic        done_reg;

    logic [31:0] e1, ch, t1, a0, mj, t2, s0, s1, w_new;

    // One compression round and one schedule word
    always_comb
    begin
        e1    = ror(v_reg[4], 6) ^ ror(v_reg[4], 11) ^ ror(v_reg[4], 25);
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1    = v_reg[7] + e1 + ch + K[rnd_reg] + w_reg[0];
        a0    = ror(v_reg[0], 2) ^ ror(v_reg[0], 13) ^ ror(v_reg[0], 22);
        mj    = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2    = a0 + mj;
        s0    = ror(w_reg[1], 7) ^ ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1    = ror(w_reg[14], 17) ^ ror(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_reg  <= '0;
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                rnd_reg <= '0;
            end
            else if (run_reg)
            begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= init ? IV[i] : h_reg[i];
                if (init)
                    h_reg[i] <= IV[i];
            end
            for (int i = 0; i < 16; i++)
                w_reg[i] <= block[511 - 32*i -: 32];
        end
        else if (run_reg)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_new;
        end
        else if (fin_reg)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= h_reg[i] + v_reg[i];
        end
    end

    assign busy   = run_reg | fin_reg;
    assign done   = done_reg;
    assign digest = {h_reg[0], h_reg[1], h_reg[2], h_reg[3],
                     h_reg[4], h_reg[5], h_reg[6], h_reg[7]};

endmodule

// ===== rtl/afrf_sender_table.sv =====
module afrf_sender_table #(
    parameter int SENDER_SLOTS = afrf_pkg::DEF_SENDER_SLOTS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  afrf_pkg::tbl_req_t req,
    input  logic [31:0]        who,
    input  logic [63:0]        ctr,
    output afrf_pkg::tbl_rsp_t rsp
);
    import afrf_pkg::*;

    localparam int IW = (SENDER_SLOTS > 1) ? $clog2(SENDER_SLOTS) : 1;
    localparam int CW = $clog2(SENDER_SLOTS + 1);
    localparam logic [IW-1:0] LAST_SLOT = IW'(SENDER_SLOTS - 1);
    localparam logic [CW-1:0] SLOT_CNT  = CW'(SENDER_SLOTS);

    logic [31:0] sender_mem  [SENDER_SLOTS];
    logic [63:0] counter_mem [SENDER_SLOTS];

    logic [SENDER_SLOTS-1:0] valid_reg;
    logic [31:0]             rd_sender;
    logic [63:0]             rd_counter;
    logic                    scan_reg;
    logic [CW-1:0]           rd_idx_reg;
    logic                    pend_reg;
    logic [IW-1:0]           slot_d_reg;
    logic                    hit_reg;
    logic [IW-1:0]           hit_idx_reg;
    logic [63:0]             prev_reg;
    logic                    done_reg;
    logic [IW-1:0]           ptr_reg;

    logic          rd_en;
    logic          match_now;
    logic          finish;
    logic [IW-1:0] wr_idx;

    // Scan one slot per cycle
    assign rd_en     = scan_reg && (rd_idx_reg < SLOT_CNT);
    assign match_now = pend_reg && valid_reg[slot_d_reg] && (rd_sender == who);
    assign finish    = scan_reg && pend_reg && (match_now || (slot_d_reg == LAST_SLOT));
    assign wr_idx    = hit_reg ? hit_idx_reg : ptr_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_sender  <= sender_mem[rd_idx_reg[IW-1:0]];
            rd_counter <= counter_mem[rd_idx_reg[IW-1:0]];
        end
        if (req.upd)
        begin
            sender_mem[wr_idx]  <= who;
            counter_mem[wr_idx] <= ctr;
        end
        if (finish)
        begin
            hit_idx_reg <= slot_d_reg;
            prev_reg    <= match_now ? rd_counter : 64'd0;
        end
        slot_d_reg <= rd_idx_reg[IW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            scan_reg   <= 1'b0;
            rd_idx_reg <= '0;
            pend_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            done_reg   <= 1'b0;
            ptr_reg    <= '0;
        end
        else
        begin
            done_reg <= finish;
            pend_reg <= rd_en;
            if (req.scan)
            begin
                scan_reg   <= 1'b1;
                rd_idx_reg <= '0;
                pend_reg   <= 1'b0;
                hit_reg    <= 1'b0;
            end
            else
            begin
                if (rd_en)
                    rd_idx_reg <= rd_idx_reg + CW'(1);
                if (finish)
                begin
                    scan_reg <= 1'b0;
                    hit_reg  <= match_now;
                end
            end
            // New sender takes the round-robin slot
            if (req.upd && !hit_reg)
            begin
                valid_reg[ptr_reg] <= 1'b1;
                ptr_reg <= (ptr_reg == LAST_SLOT) ? '0 : ptr_reg + IW'(1);
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.hit  = hit_reg;
    assign rsp.prev = prev_reg;

endmodule

// ===== rtl/authenticated_frame_relay_filter_unit.sv =====
// Channel   | Signals                                        | Word
// ----------+------------------------------------------------+---------------------------
// in        | in_valid, in_ready, frame_byte, last_byte      | one frame byte
// out       | out_valid, out_ready, status, new_ttl, tags    | one verdict per frame
// cfg (APB) | psel, penable, pwrite, paddr, pwdata, prdata   | 64-bit register at 8*index
//
// Non-final bytes are taken one per cycle. The final byte starts the checks; a
// SHA-256 block is a byte fill from the frame RAM followed by 64 rounds of the
// shared round engine. One HMAC is ceil((S+73)/64)+2 blocks for S signed bytes;
// a forwarded frame runs two HMACs and a scan of up to SENDER_SLOTS slots of
// the sender table. No clearing pass after reset.
// A pending verdict does not block the next frame's bytes.
module authenticated_frame_relay_filter_unit #(
    parameter int MAX_FRAME_BYTES = afrf_pkg::DEF_MAX_FRAME_BYTES,
    parameter int SENDER_SLOTS    = afrf_pkg::DEF_SENDER_SLOTS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  frame_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [7:0]  new_ttl,
    output logic [63:0] new_tag_high,
    output logic [63:0] new_tag_low
);
    import afrf_pkg::*;

    localparam int AW = $clog2(MAX_FRAME_BYTES);
    localparam int CW = $clog2(MAX_FRAME_BYTES + 2);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAME_BYTES);

    // Configuration registers
    logic [15:0] net_reg;
    logic [63:0] key_reg [4];
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            net_reg <= 16'h484C;
            for (int i = 0; i < 4; i++)
                key_reg[i] <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[5:3])
                REG_NETWORK: net_reg    <= pwdata[15:0];
                REG_KEY0:    key_reg[0] <= pwdata;
                REG_KEY1:    key_reg[1] <= pwdata;
                REG_KEY2:    key_reg[2] <= pwdata;
                REG_KEY3:    key_reg[3] <= pwdata;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[5:3])
            REG_NETWORK: prdata = {48'd0, net_reg};
            REG_KEY0:    prdata = key_reg[0];
            REG_KEY1:    prdata = key_reg[1];
            REG_KEY2:    prdata = key_reg[2];
            REG_KEY3:    prdata = key_reg[3];
            default:     prdata = '0;
        endcase
    end

    // State
    afrf_state_t state_reg, state_next;

    logic [7:0]    frame_mem [MAX_FRAME_BYTES];
    logic [7:0]    mem_rd_reg;
    logic [CW-1:0] cnt_reg;
    logic [7:0]    hdr_reg [HDR_BYTES];
    logic [127:0]  tag_sr_reg;
    logic          pass2_reg;
    logic          outer_reg;
    logic [3:0]    blk_reg;
    logic [6:0]    fill_reg;
    logic          bvalid_reg;
    logic          blast_reg;
    logic          bmem_reg;
    logic [7:0]    bconst_reg;
    logic [511:0]  block_reg;
    logic [255:0]  inner_reg;
    logic [2:0]    res_status_reg;
    logic [127:0]  res_tag_reg;
    logic          out_valid_reg;
    logic [2:0]    out_status_reg;
    logic [7:0]    out_ttl_reg;
    logic [127:0]  out_tag_reg;

    // Core and table links
    logic         core_start;
    logic         core_busy;
    logic         core_done;
    logic [255:0] core_digest;
    tbl_req_t     tbl_req;
    tbl_rsp_t     tbl_rsp;

    // Frame fields
    logic [9:0]   len10;
    logic [9:0]   slen10;
    logic [31:0]  who;
    logic [63:0]  ctr;
    logic [7:0]   ttl_dec;
    logic         len_bad, hdr_bad, net_bad, plen_bad;
    logic         accept_in;

    assign accept_in = in_valid && in_ready;
    assign len10     = 10'(cnt_reg);
    assign slen10    = 10'd19 + {2'b00, hdr_reg[18]};
    assign who       = {hdr_reg[5], hdr_reg[6], hdr_reg[7], hdr_reg[8]};
    assign ctr       = {hdr_reg[9], hdr_reg[10], hdr_reg[11], hdr_reg[12],
                        hdr_reg[13], hdr_reg[14], hdr_reg[15], hdr_reg[16]};
    assign ttl_dec   = hdr_reg[17] - 8'd1;
    assign len_bad   = (len10 < 10'(MIN_FRAME_BYTES)) || (len10 > 10'(MAX_FRAME_BYTES));
    assign hdr_bad   = (hdr_reg[0] != MAGIC_0) || (hdr_reg[1] != MAGIC_1)
                       || (hdr_reg[2] != VERSION);
    assign net_bad   = {hdr_reg[3], hdr_reg[4]} != net_reg;
    assign plen_bad  = (slen10 + 10'(TAG_BYTES)) != len10;

    // Padded message geometry for the current hash
    logic [9:0]   mlen10;
    logic [9:0]   pad_sum10;
    logic [3:0]   tot_blk;
    logic [9:0]   tot_bytes10;
    logic [9:0]   pos10;
    logic [9:0]   m10;
    logic [63:0]  bitlen64;
    logic [255:0] key_all;
    logic [4:0]   kidx, iidx;
    logic [2:0]   lidx;
    logic         blk_last;
    logic         issue;
    logic         src_mem;
    logic [7:0]   src_const;
    logic         tag_bad;
    logic         replay;
    logic         mac_final;

    assign mlen10      = outer_reg ? 10'd32 : slen10;
    assign pad_sum10   = mlen10 + 10'd136;
    assign tot_blk     = pad_sum10[9:6];
    assign tot_bytes10 = {tot_blk, 6'd0};
    assign pos10       = {blk_reg, fill_reg[5:0]};
    assign m10         = pos10 - 10'd64;
    assign bitlen64    = {51'd0, mlen10 + 10'd64, 3'b000};
    assign key_all     = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
    assign kidx        = 5'd31 - pos10[4:0];
    assign iidx        = 5'd31 - m10[4:0];
    assign lidx        = 3'd7 - pos10[2:0];
    assign blk_last    = (blk_reg + 4'd1) == tot_blk;
    assign issue       = (state_reg == S_FILL) && !fill_reg[6];
    assign tag_bad     = core_digest[255:128] != tag_sr_reg;
    assign replay      = ctr <= (tbl_rsp.hit ? tbl_rsp.prev : 64'd0);
    assign mac_final   = core_done && blk_last && outer_reg;

    // Byte source for the block being assembled
    always_comb
    begin
        src_mem   = 1'b0;
        src_const = 8'd0;
        if (pos10 < 10'd64)
        begin
            src_const = (pos10[5] ? 8'd0 : key_all[{kidx, 3'b000} +: 8])
                        ^ (outer_reg ? OPAD : IPAD);
        end
        else if (m10 < mlen10)
        begin
            if (outer_reg)
                src_const = inner_reg[{iidx, 3'b000} +: 8];
            else if (pass2_reg && (m10 == 10'd17))
                src_const = ttl_dec;
            else
                src_mem = 1'b1;
        end
        else if (m10 == mlen10)
        begin
            src_const = PAD_MARK;
        end
        else if (pos10 >= (tot_bytes10 - 10'd8))
        begin
            src_const = bitlen64[{lidx, 3'b000} +: 8];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_COLLECT:
            begin
                if (accept_in && last_byte)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (len_bad || hdr_bad || net_bad || plen_bad)
                    state_next = S_RESULT;
                else
                    state_next = S_FILL;
            end
            S_FILL:
            begin
                if (blast_reg)
                    state_next = S_START;
            end
            S_START:
            begin
                state_next = S_HASH;
            end
            S_HASH:
            begin
                if (core_done)
                begin
                    if (!mac_final)
                        state_next = S_FILL;
                    else if (!pass2_reg && !tag_bad)
                        state_next = S_LOOKUP;
                    else
                        state_next = S_RESULT;
                end
            end
            S_LOOKUP:
            begin
                if (tbl_rsp.done)
                begin
                    if (replay || (hdr_reg[17] == 8'd0))
                        state_next = S_RESULT;
                    else
                        state_next = S_FILL;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_COLLECT;
            end
            default: state_next = S_COLLECT;
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready     = 1'b0;
        core_start   = 1'b0;
        tbl_req.scan = 1'b0;
        tbl_req.upd  = 1'b0;
        case (state_reg)
            S_COLLECT: in_ready   = 1'b1;
            S_START:   core_start = 1'b1;
            S_HASH:    tbl_req.scan = mac_final && !pass2_reg && !tag_bad;
            S_LOOKUP:  tbl_req.upd  = tbl_rsp.done && !replay && (hdr_reg[17] != 8'd0);
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_COLLECT;
        else
            state_reg <= state_next;
    end

    // Frame RAM: write while collecting, read while filling
    always_ff @(posedge clk)
    begin
        if (accept_in && (cnt_reg < MAX_CNT))
            frame_mem[cnt_reg[AW-1:0]] <= frame_byte;
        if (issue)
            mem_rd_reg <= frame_mem[m10[AW-1:0]];
    end

    // Header capture, tag window, block assembly, digest capture and verdict word
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            for (int i = 0; i < HDR_BYTES; i++)
                if (cnt_reg == CW'(i))
                    hdr_reg[i] <= frame_byte;
            tag_sr_reg <= {tag_sr_reg[119:0], frame_byte};
        end
        bmem_reg   <= src_mem;
        bconst_reg <= src_const;
        if (bvalid_reg)
            block_reg <= {block_reg[503:0], bmem_reg ? mem_rd_reg : bconst_reg};
        if (state_reg == S_HASH && core_done && blk_last && !outer_reg)
            inner_reg <= core_digest;
        if (state_reg == S_HASH && mac_final)
            res_tag_reg <= core_digest[255:128];
        if (state_reg == S_RESULT && state_next == S_COLLECT)
        begin
            out_status_reg <= res_status_reg;
            out_ttl_reg    <= (res_status_reg == ST_FORWARD) ? ttl_dec : 8'd0;
            out_tag_reg    <= (res_status_reg == ST_FORWARD) ? res_tag_reg : 128'd0;
        end
    end

    // Sequencing control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            pass2_reg      <= 1'b0;
            outer_reg      <= 1'b0;
            blk_reg        <= '0;
            fill_reg       <= '0;
            bvalid_reg     <= 1'b0;
            blast_reg      <= 1'b0;
            res_status_reg <= ST_FORWARD;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            bvalid_reg <= issue;
            blast_reg  <= issue && (fill_reg == 7'd63);
            if (issue)
                fill_reg <= fill_reg + 7'd1;
            if (accept_in && (cnt_reg <= MAX_CNT))
                cnt_reg <= cnt_reg + CW'(1);

            case (state_reg)
                S_CHECK:
                begin
                    pass2_reg <= 1'b0;
                    outer_reg <= 1'b0;
                    blk_reg   <= '0;
                    fill_reg  <= '0;
                    if (len_bad)
                        res_status_reg <= ST_BAD_LEN;
                    else if (hdr_bad)
                        res_status_reg <= ST_BAD_HDR;
                    else if (net_bad)
                        res_status_reg <= ST_BAD_NET;
                    else if (plen_bad)
                        res_status_reg <= ST_LEN_MISM;
                end
                S_HASH:
                begin
                    if (core_done)
                    begin
                        fill_reg <= '0;
                        if (!blk_last)
                        begin
                            blk_reg <= blk_reg + 4'd1;
                        end
                        else if (!outer_reg)
                        begin
                            outer_reg <= 1'b1;
                            blk_reg   <= '0;
                        end
                        else if (!pass2_reg && tag_bad)
                        begin
                            res_status_reg <= ST_BAD_TAG;
                        end
                        else if (pass2_reg)
                        begin
                            res_status_reg <= ST_FORWARD;
                        end
                    end
                end
                S_LOOKUP:
                begin
                    if (tbl_rsp.done)
                    begin
                        if (replay)
                            res_status_reg <= ST_REPLAY;
                        else if (hdr_reg[17] == 8'd0)
                            res_status_reg <= ST_TTL_ZERO;
                        else
                        begin
                            pass2_reg <= 1'b1;
                            outer_reg <= 1'b0;
                            blk_reg   <= '0;
                            fill_reg  <= '0;
                        end
                    end
                end
                S_RESULT:
                begin
                    if (state_next == S_COLLECT)
                        cnt_reg <= '0;
                end
                default: ;
            endcase

            if (state_reg == S_RESULT && state_next == S_COLLECT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    afrf_sha_core u_sha (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (core_start),
        .init   (blk_reg == 4'd0),
        .block  (block_reg),
        .busy   (core_busy),
        .done   (core_done),
        .digest (core_digest)
    );

    afrf_sender_table #(
        .SENDER_SLOTS (SENDER_SLOTS)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tbl_req),
        .who   (who),
        .ctr   (ctr),
        .rsp   (tbl_rsp)
    );

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign new_ttl      = out_ttl_reg;
    assign new_tag_high = out_tag_reg[127:64];
    assign new_tag_low  = out_tag_reg[63:0];

    // Checks
    a_core_idle: assert property (@(posedge clk) disable iff (!rst_n)
        core_start |-> !core_busy)
        else $error("round engine started while busy");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_FORWARD) |->
            (new_ttl == 8'd0 && new_tag_high == 64'd0 && new_tag_low == 64'd0))
        else $error("rejected word carries ttl or tag");

    a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_FRAME_BYTES + 1))
        else $error("byte count past saturation");

    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_RESULT))
        else $error("verdict loaded outside result state");

endmodule
